[hw/rtl/fbcs_pkg.sv]
package fbcs_pkg;

	// item opcodes
	localparam logic [1:0] OP_TICK      = 2'd0;
	localparam logic [1:0] OP_SET       = 2'd1;
	localparam logic [1:0] OP_CLEAR     = 2'd2;
	localparam logic [1:0] OP_CLEAR_ALL = 2'd3;

	// blink phases
	localparam logic [2:0] PH_IDLE   = 3'd0;	// drive high, start next code
	localparam logic [2:0] PH_LOW    = 3'd1;	// pulse low half
	localparam logic [2:0] PH_HIGH   = 3'd2;	// pulse high half
	localparam logic [2:0] PH_PAUSE1 = 3'd3;
	localparam logic [2:0] PH_PAUSE2 = 3'd4;
	localparam logic [2:0] PH_PAUSE3 = 3'd5;

	localparam int CODE_W     = 5;
	localparam int LIST_DEPTH = 32;
	localparam int LIST_AW    = 5;
	localparam int CNT_W      = 6;

	typedef struct packed {
		logic [1:0]        op;
		logic [CODE_W-1:0] fault_num;
		logic [7:0]        set_val;
	} item_t;

	typedef struct packed {
		logic              led;
		logic [CODE_W-1:0] active_code;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN_START,
		ST_SCAN_HOLD,
		ST_CHECK,
		ST_LOAD,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic cap;
		logic edit;
		logic step;
		logic led_on;
		logic scan_init;
		logic scan_step;
		logic rd;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic phase_zero;
		logic list_ready;
		logic count_nz;
		logic scan_last;
	} stat_t;

endpackage

[hw/rtl/fbcs_ram.sv]
module fbcs_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/fbcs_ctrl.sv]
module fbcs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  fbcs_pkg::stat_t stat,
	output fbcs_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);

	fbcs_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			fbcs_pkg::ST_IDLE: begin
				cmd.cap = start;
				if (start) begin
					state_d = fbcs_pkg::ST_EXEC;
				end
			end
			fbcs_pkg::ST_EXEC: begin
				if (!stat.is_tick) begin
					cmd.edit = 1'b1;
					state_d  = fbcs_pkg::ST_DONE;
				end else if (!stat.phase_zero) begin
					cmd.step = 1'b1;
					state_d  = fbcs_pkg::ST_DONE;
				end else begin
					cmd.led_on = 1'b1;
					if (stat.list_ready) begin
						cmd.rd  = 1'b1;
						state_d = fbcs_pkg::ST_LOAD;
					end else begin
						cmd.scan_init = 1'b1;
						// list used up: start a code after the scan; empty list: just rebuild
						state_d = stat.count_nz ? fbcs_pkg::ST_SCAN_START
						                        : fbcs_pkg::ST_SCAN_HOLD;
					end
				end
			end
			fbcs_pkg::ST_SCAN_START: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = fbcs_pkg::ST_CHECK;
				end
			end
			fbcs_pkg::ST_SCAN_HOLD: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = fbcs_pkg::ST_DONE;
				end
			end
			fbcs_pkg::ST_CHECK: begin
				if (stat.count_nz) begin
					cmd.rd  = 1'b1;
					state_d = fbcs_pkg::ST_LOAD;
				end else begin
					state_d = fbcs_pkg::ST_DONE;
				end
			end
			fbcs_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = fbcs_pkg::ST_DONE;
			end
			fbcs_pkg::ST_DONE: begin
				state_d = fbcs_pkg::ST_IDLE;
			end
			default: begin
				state_d = fbcs_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != fbcs_pkg::ST_IDLE);
	assign done = (state_q == fbcs_pkg::ST_DONE);

endmodule

[hw/rtl/fbcs_dp.sv]
module fbcs_dp #(
	parameter int NUM_FAULTS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fbcs_pkg::item_t   item,
	input  fbcs_pkg::cmd_t    cmd,
	output fbcs_pkg::stat_t   stat,
	output fbcs_pkg::result_t result
);

	// only numbers below min(NUM_FAULTS, 32) are addressable; the scan covers numbers 1 and up
	localparam int FLAG_N = (NUM_FAULTS < 32) ? NUM_FAULTS : 32;
	localparam int FLAG_W = $clog2(FLAG_N);

	fbcs_pkg::item_t                 item_q;
	logic [FLAG_N-1:0]               flags_q;
	logic [FLAG_W-1:0]               scan_n_q;
	logic [fbcs_pkg::CNT_W-1:0]      count_q;
	logic [fbcs_pkg::CNT_W-1:0]      index_q;
	logic [fbcs_pkg::CODE_W-1:0]     pulses_q;
	logic [2:0]                      phase_q;
	logic                            led_q;
	logic [fbcs_pkg::CODE_W-1:0]     cur_code_q;
	logic [fbcs_pkg::CODE_W-1:0]     rdata;
	logic                            id_ok;
	logic [FLAG_W-1:0]               id_idx;
	logic                            hit;

	assign id_ok  = (32'(item_q.fault_num) < FLAG_N);
	assign id_idx = item_q.fault_num[FLAG_W-1:0];
	assign hit    = flags_q[scan_n_q];

	fbcs_ram #(
		.WIDTH(fbcs_pkg::CODE_W),
		.DEPTH(fbcs_pkg::LIST_DEPTH)
	) u_list (
		.clk  (clk),
		.we   (cmd.scan_step && hit),
		.waddr(count_q[fbcs_pkg::LIST_AW-1:0]),
		.wdata(fbcs_pkg::CODE_W'(scan_n_q)),
		.re   (cmd.rd),
		.raddr(index_q[fbcs_pkg::LIST_AW-1:0]),
		.rdata(rdata)
	);

	// payload
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			item_q <= item;
		end
		if (cmd.scan_init) begin
			scan_n_q <= FLAG_W'(1);
		end else if (cmd.scan_step) begin
			scan_n_q <= scan_n_q + FLAG_W'(1);
		end
		if (cmd.load) begin
			cur_code_q <= rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= '0;
			count_q  <= '0;
			index_q  <= '0;
			pulses_q <= '0;
			phase_q  <= fbcs_pkg::PH_IDLE;
			led_q    <= 1'b0;
		end else begin
			if (cmd.edit) begin
				unique case (item_q.op)
					fbcs_pkg::OP_SET: begin
						if (id_ok) begin
							flags_q[id_idx] <= (item_q.set_val != 8'd0);
						end
					end
					fbcs_pkg::OP_CLEAR: begin
						if (id_ok) begin
							flags_q[id_idx] <= 1'b0;
						end
					end
					fbcs_pkg::OP_CLEAR_ALL: begin
						flags_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.step) begin
				case (phase_q)
					fbcs_pkg::PH_LOW: begin
						led_q   <= 1'b0;
						phase_q <= (pulses_q != '0) ? fbcs_pkg::PH_HIGH : fbcs_pkg::PH_PAUSE1;
					end
					fbcs_pkg::PH_HIGH: begin
						led_q    <= 1'b1;
						pulses_q <= pulses_q - fbcs_pkg::CODE_W'(1);
						phase_q  <= fbcs_pkg::PH_LOW;
					end
					fbcs_pkg::PH_PAUSE1: begin
						led_q   <= 1'b0;
						phase_q <= fbcs_pkg::PH_PAUSE2;
					end
					fbcs_pkg::PH_PAUSE2: begin
						led_q   <= 1'b0;
						phase_q <= fbcs_pkg::PH_PAUSE3;
					end
					fbcs_pkg::PH_PAUSE3: begin
						led_q   <= 1'b0;
						phase_q <= fbcs_pkg::PH_IDLE;
						index_q <= index_q + fbcs_pkg::CNT_W'(1);
					end
					default: begin
						led_q   <= 1'b0;
						phase_q <= fbcs_pkg::PH_IDLE;
					end
				endcase
			end
			if (cmd.led_on) begin
				led_q <= 1'b1;
			end
			if (cmd.scan_init) begin
				count_q <= '0;
				index_q <= '0;
			end else if (cmd.scan_step && hit) begin
				count_q <= count_q + fbcs_pkg::CNT_W'(1);
			end
			if (cmd.load) begin
				pulses_q <= rdata - fbcs_pkg::CODE_W'(1);
				phase_q  <= fbcs_pkg::PH_LOW;
			end
		end
	end

	assign stat.is_tick    = (item_q.op == fbcs_pkg::OP_TICK);
	assign stat.phase_zero = (phase_q == fbcs_pkg::PH_IDLE);
	assign stat.count_nz   = (count_q != '0);
	assign stat.list_ready = (count_q != '0) && (index_q < count_q);
	assign stat.scan_last  = (scan_n_q == FLAG_W'(FLAG_N - 1));

	assign result.led         = led_q;
	assign result.active_code = (phase_q >= fbcs_pkg::PH_LOW && phase_q <= fbcs_pkg::PH_PAUSE3)
	                            ? cur_code_q : '0;

endmodule

[hw/rtl/fault_blink_code_sequencer.sv]
// Channel   Handshake           Payload                       Direction
// ------    ---------           -------                       ---------
// item      start / busy        fbcs_pkg::item_t  item        in
// result    done (strobe)       fbcs_pkg::result_t result     out
//
// An item transfers on a rising edge with start high and busy low; busy then
// stays high until the result has been shown.
// Edits and mid-code ticks go from EXEC to DONE; a tick that starts the next
// code goes through LOAD (one list RAM read); a tick that rebuilds the list
// scans one fault flag per cycle, then, if the old list was used up, checks
// for a new code to load. The next item can transfer in the cycle after done.
// done is high for exactly one cycle with result valid; the receiver cannot
// stall it. arst_n clears the flags, counters, blink phase and LED at once;
// the code list RAM is not cleared, it is always written before it is read.
module fault_blink_code_sequencer #(
	parameter int NUM_FAULTS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fbcs_pkg::item_t   item,
	output logic              done,
	output fbcs_pkg::result_t result
);

	// controller drives the datapath through a command bundle only
	fbcs_pkg::cmd_t  cmd;
	fbcs_pkg::stat_t stat;

	fbcs_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// flags, list RAM, blink phase counter and LED level
	fbcs_dp #(
		.NUM_FAULTS(NUM_FAULTS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.stat  (stat),
		.result(result)
	);

endmodule

[hw/rtl/fbcs_checker.sv]
module fbcs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input fbcs_pkg::result_t result
);

	// accepted item holds the block busy
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("busy not raised after transfer");

	// one result per item
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");

	// result closes the item
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("busy still high after result");

	// no result without an item in flight
	assert property (@(posedge clk) disable iff (!arst_n) !busy |-> !done)
		else $error("result while idle");

	// result fields are driven whenever the strobe is up
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !$isunknown(result))
		else $error("result unknown at strobe");

endmodule

bind fault_blink_code_sequencer fbcs_checker u_fbcs_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
